// ----- design/bca_pkg.sv -----
// ----------------------------------------------------------------------------
// bca_pkg
// Shared types and constants of the barometer compensation block.
// ----------------------------------------------------------------------------
package bca_pkg;

    localparam int WINDOW_SAMPLES = 16;
    localparam int RING_AW        = $clog2(WINDOW_SAMPLES);
    localparam int TOTAL_W        = 32 + $clog2(WINDOW_SAMPLES);
    localparam int DIV_W          = 32;
    localparam int DIV_CNT_W      = $clog2(DIV_W + 1);
    localparam int SLOW_W         = 48;
    localparam int ALPHA_BITS     = 11;
    localparam int BIT_W          = $clog2(ALPHA_BITS);
    localparam int ACC_W          = SLOW_W + 16;

    localparam logic [ALPHA_BITS-1:0] SLOW_ALPHA = 11'd1311;
    localparam logic [31:0] COMP_MG   = 32'd3038;
    localparam logic [31:0] COMP_MH   = 32'hFFFF_E343;
    localparam logic [31:0] COMP_MI   = 32'd3791;
    localparam logic [31:0] TEMP_OFS  = 32'd4000;
    localparam logic [31:0] B4_OFS    = 32'd32768;
    localparam logic [31:0] B7_SCALE  = 32'd50000;

    localparam logic [2:0] CFG_AC1_AC2  = 3'd0;
    localparam logic [2:0] CFG_AC3_AC4  = 3'd1;
    localparam logic [2:0] CFG_AC5_AC6  = 3'd2;
    localparam logic [2:0] CFG_B1_B2    = 3'd3;
    localparam logic [2:0] CFG_MC_MD    = 3'd4;
    localparam logic [2:0] CFG_OSS      = 3'd5;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_USE   = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_SCALE = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    typedef enum logic [3:0] {
        STP_X1, STP_SQ, STP_B2SQ, STP_AC2, STP_AC3, STP_B1SQ,
        STP_B4, STP_B7, STP_PSQ, STP_PMG, STP_PMH
    } t_step;

    typedef enum logic [1:0] {
        DK_TEMP, DK_PRES, DK_MEAN
    } t_div_kind;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

    function automatic logic [31:0] f_sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] f_asr(input logic [31:0] v, input int unsigned n);
        logic signed [31:0] s;
        s = signed'(v);
        return 32'(s >>> n);
    endfunction

endpackage

// ----- design/bca_ram.sv -----
// ----------------------------------------------------------------------------
// bca_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/bca_div.sv -----
// ----------------------------------------------------------------------------
// bca_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bca_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bca_pkg::t_div_req i_req,
    output bca_pkg::t_div_rsp o_rsp
);
    import bca_pkg::*;

    logic [DIV_W-1:0]     r_rem, n_rem;
    logic [DIV_W-1:0]     r_quo, n_quo;
    logic [DIV_W-1:0]     r_den, n_den;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_W:0]       w_sh;
    logic [DIV_W:0]       w_sub;

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_sh   = {r_rem, r_quo[DIV_W-1]};
        w_sub  = w_sh - {1'b0, r_den};
        if (i_req.start) begin
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_den  = i_req.divisor;
            n_cnt  = DIV_CNT_W'(DIV_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_sub[DIV_W]) begin
                n_rem = w_sub[DIV_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = w_sh[DIV_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

// ----- design/barometer_compensation_average.sv -----
// ----------------------------------------------------------------------------
// barometer_compensation_average
// Pressure and temperature compensation with moving and slow pressure mean.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready) takes one word: raw temperature and raw
// pressure. Output channel (o_valid/i_ready) gives one word per input: the
// compensated temperature, pressure, moving mean, slow Q.16 average and the
// divide fault flag. Configuration words (i_cfg_valid/o_cfg_ready) load the
// calibration pairs and the oversampling code; the port is always ready, and
// the user must write it only while the block is idle; the block does not enforce this.
// One word is processed at a time. Between acceptance and o_valid the word
// makes eleven passes through the shared 32x32 multiplier, two runs of the
// serial divider (temperature term and pressure quotient), the window mean
// and alpha scaling over the eleven alpha bits. A zero divisor skips its
// divider run. o_ready is low from acceptance until the result word is
// taken; a stalled receiver holds the result and the block. Reset clears
// the sample window, the running sum and the slow average, and sets
// oversampling to 3.
// ----------------------------------------------------------------------------
module barometer_compensation_average (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_raw_temperature,
    input  logic [23:0] i_raw_pressure,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [15:0] o_temperature_decideg,
    output logic signed [31:0] o_pressure_pa,
    output logic signed [31:0] o_pressure_mean_pa,
    output logic signed [47:0] o_pressure_slow_q16,
    output logic        o_divide_fault
);
    import bca_pkg::*;

    logic [31:0] r_c0, r_c1, r_c2, r_c3, r_c4;
    logic [1:0]  r_oss;

    t_state      r_state, n_state;
    t_step       r_step, n_step;
    t_div_kind   r_kind, n_kind;
    logic [31:0] r_up, n_up;
    logic [15:0] r_ut, n_ut;
    logic [31:0] r_x1, n_x1, r_b5, n_b5, r_b6, n_b6, r_sq, n_sq;
    logic [31:0] r_x3, n_x3, r_b3, n_b3, r_b4, n_b4, r_b7, n_b7;
    logic [31:0] r_p, n_p, r_tmp, n_tmp, r_prod, n_prod, r_mean, n_mean;
    logic        r_sign, n_sign, r_fault, n_fault;
    logic [TOTAL_W-1:0]        r_total, n_total;
    logic [RING_AW-1:0]        r_pos, n_pos;
    logic [WINDOW_SAMPLES-1:0] r_vld, n_vld;
    logic [SLOW_W-1:0]         r_slow, n_slow;
    logic [ACC_W-1:0]          r_diff, n_diff, r_acc, n_acc;
    logic [BIT_W-1:0]          r_bit, n_bit;

    logic [31:0] w_ac1, w_ac2, w_ac3, w_ac4, w_ac5, w_ac6;
    logic [31:0] w_b1, w_b2, w_mc, w_md;
    logic [31:0] w_ma, w_mb, w_prod;
    logic [31:0] w_den, w_num, w_q32, w_x2, w_x3v, w_pn, w_old, w_t8;
    logic [TOTAL_W-1:0] w_tn, w_tq;
    logic [31:0]        w_mean;
    logic [ACC_W-1:0]   w_acc;
    logic [31:0]        w_ram_rdata;
    logic               w_ram_we, w_ram_re;
    t_div_req           w_req;
    t_div_rsp           w_rsp;

    assign w_ac1 = f_sx16(r_c0[31:16]);
    assign w_ac2 = f_sx16(r_c0[15:0]);
    assign w_ac3 = f_sx16(r_c1[31:16]);
    assign w_ac4 = {16'd0, r_c1[15:0]};
    assign w_ac5 = {16'd0, r_c2[31:16]};
    assign w_ac6 = {16'd0, r_c2[15:0]};
    assign w_b1  = f_sx16(r_c3[31:16]);
    assign w_b2  = f_sx16(r_c3[15:0]);
    assign w_mc  = f_sx16(r_c4[31:16]);
    assign w_md  = f_sx16(r_c4[15:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0  <= '0;
            r_c1  <= '0;
            r_c2  <= '0;
            r_c3  <= '0;
            r_c4  <= '0;
            r_oss <= 2'd3;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_AC1_AC2: r_c0  <= i_cfg_data;
                CFG_AC3_AC4: r_c1  <= i_cfg_data;
                CFG_AC5_AC6: r_c2  <= i_cfg_data;
                CFG_B1_B2:   r_c3  <= i_cfg_data;
                CFG_MC_MD:   r_c4  <= i_cfg_data;
                CFG_OSS:     r_oss <= i_cfg_data[1:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        case (r_step)
            STP_X1:   begin w_ma = {16'd0, r_ut} - w_ac6; w_mb = w_ac5; end
            STP_SQ:   begin w_ma = r_b6;                 w_mb = r_b6;  end
            STP_B2SQ: begin w_ma = w_b2;                 w_mb = r_sq;  end
            STP_AC2:  begin w_ma = w_ac2;                w_mb = r_b6;  end
            STP_AC3:  begin w_ma = w_ac3;                w_mb = r_b6;  end
            STP_B1SQ: begin w_ma = w_b1;                 w_mb = r_sq;  end
            STP_B4:   begin w_ma = w_ac4;                w_mb = r_x3 + B4_OFS; end
            STP_B7:   begin w_ma = r_up - r_b3;          w_mb = B7_SCALE >> r_oss; end
            STP_PSQ:  begin w_ma = r_x1;                 w_mb = r_x1;  end
            STP_PMG:  begin w_ma = r_tmp;                w_mb = COMP_MG; end
            STP_PMH:  begin w_ma = COMP_MH;              w_mb = r_p;   end
            default:  begin w_ma = '0;                   w_mb = '0;    end
        endcase
        w_prod = w_ma * w_mb;
    end

    assign w_den  = f_asr(r_prod, 15) + w_md;
    assign w_num  = w_mc << 11;
    assign w_q32  = w_rsp.quotient[31:0];
    assign w_x2   = r_sign ? (32'd0 - w_q32) : w_q32;
    assign w_x3v  = r_x3 + f_asr(r_prod, 11);
    assign w_pn   = r_p + f_asr(r_x1 + f_asr(r_prod, 16) + COMP_MI, 4);
    assign w_old  = r_vld[r_pos] ? w_ram_rdata : 32'd0;
    assign w_tn   = r_total + {{(TOTAL_W-32){w_pn[31]}}, w_pn}
                  - {{(TOTAL_W-32){w_old[31]}}, w_old};
    assign w_tq   = r_total + (r_total[TOTAL_W-1] ? TOTAL_W'(WINDOW_SAMPLES - 1) : '0);
    assign w_mean = w_tq[RING_AW +: 32];
    assign w_acc  = r_acc + (SLOW_ALPHA[r_bit] ? r_diff : '0);
    assign w_t8   = r_b5 + 32'd8;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_kind  = r_kind;
        n_up    = r_up;
        n_ut    = r_ut;
        n_x1    = r_x1;
        n_b5    = r_b5;
        n_b6    = r_b6;
        n_sq    = r_sq;
        n_x3    = r_x3;
        n_b3    = r_b3;
        n_b4    = r_b4;
        n_b7    = r_b7;
        n_p     = r_p;
        n_tmp   = r_tmp;
        n_prod  = r_prod;
        n_mean  = r_mean;
        n_sign  = r_sign;
        n_fault = r_fault;
        n_total = r_total;
        n_pos   = r_pos;
        n_vld   = r_vld;
        n_slow  = r_slow;
        n_diff  = r_diff;
        n_acc   = r_acc;
        n_bit   = r_bit;
        w_req   = '0;
        w_ram_we = 1'b0;
        w_ram_re = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_ut     = i_raw_temperature;
                    n_up     = 32'({8'd0, i_raw_pressure} >> (4'd8 - {2'd0, r_oss}));
                    n_fault  = 1'b0;
                    n_step   = STP_X1;
                    w_ram_re = 1'b1;
                    n_state  = ST_MUL;
                end
            end
            ST_MUL: begin
                n_prod  = w_prod;
                n_state = ST_USE;
            end
            ST_USE: begin
                n_state = ST_MUL;
                case (r_step)
                    STP_X1: begin
                        n_x1 = f_asr(r_prod, 15);
                        if (w_den == 32'd0) begin
                            n_fault = 1'b1;
                            n_b5    = f_asr(r_prod, 15);
                            n_b6    = f_asr(r_prod, 15) - TEMP_OFS;
                            n_step  = STP_SQ;
                        end else begin
                            n_sign   = w_mc[31] ^ w_den[31];
                            w_req.start    = 1'b1;
                            w_req.dividend = DIV_W'(w_mc[31] ? (32'd0 - w_num) : w_num);
                            w_req.divisor  = DIV_W'(w_den[31] ? (32'd0 - w_den) : w_den);
                            n_kind  = DK_TEMP;
                            n_state = ST_DIV;
                        end
                    end
                    STP_SQ: begin
                        n_sq   = f_asr(r_prod, 12);
                        n_step = STP_B2SQ;
                    end
                    STP_B2SQ: begin
                        n_x3   = f_asr(r_prod, 11);
                        n_step = STP_AC2;
                    end
                    STP_AC2: begin
                        n_b3   = f_asr((((w_ac1 << 2) + w_x3v) << r_oss) + 32'd2, 2);
                        n_step = STP_AC3;
                    end
                    STP_AC3: begin
                        n_x3   = f_asr(r_prod, 13);
                        n_step = STP_B1SQ;
                    end
                    STP_B1SQ: begin
                        n_x3   = f_asr(r_x3 + f_asr(r_prod, 16) + 32'd2, 2);
                        n_step = STP_B4;
                    end
                    STP_B4: begin
                        n_b4   = r_prod >> 15;
                        n_step = STP_B7;
                    end
                    STP_B7: begin
                        n_b7 = r_prod;
                        if (r_b4 == 32'd0) begin
                            n_fault = 1'b1;
                            n_p     = 32'd0;
                            n_x1    = 32'd0;
                            n_step  = STP_PSQ;
                        end else begin
                            w_req.start    = 1'b1;
                            w_req.dividend = DIV_W'(r_prod[31] ? r_prod : (r_prod << 1));
                            w_req.divisor  = DIV_W'(r_b4);
                            n_kind  = DK_PRES;
                            n_state = ST_DIV;
                        end
                    end
                    STP_PSQ: begin
                        n_tmp  = r_prod;
                        n_step = STP_PMG;
                    end
                    STP_PMG: begin
                        n_x1   = f_asr(r_prod, 16);
                        n_step = STP_PMH;
                    end
                    STP_PMH: begin
                        n_p      = w_pn;
                        n_total  = w_tn;
                        w_ram_we = 1'b1;
                        n_vld[r_pos] = 1'b1;
                        n_pos    = (r_pos == RING_AW'(WINDOW_SAMPLES - 1)) ? '0 : r_pos + 1'b1;
                        n_kind   = DK_MEAN;
                        n_state  = ST_DIV;
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_DIV: begin
                if (r_kind == DK_MEAN) begin
                    n_mean  = w_mean;
                    n_diff  = ({{(ACC_W-32){w_mean[31]}}, w_mean} << 16)
                            - {{(ACC_W-SLOW_W){r_slow[SLOW_W-1]}}, r_slow};
                    n_acc   = '0;
                    n_bit   = '0;
                    n_state = ST_SCALE;
                end else if (w_rsp.done) begin
                    case (r_kind)
                        DK_TEMP: begin
                            n_b5    = r_x1 + w_x2;
                            n_b6    = r_x1 + w_x2 - TEMP_OFS;
                            n_step  = STP_SQ;
                            n_state = ST_MUL;
                        end
                        DK_PRES: begin
                            n_p     = r_b7[31] ? (w_q32 << 1) : w_q32;
                            n_x1    = f_asr(r_b7[31] ? (w_q32 << 1) : w_q32, 8);
                            n_step  = STP_PSQ;
                            n_state = ST_MUL;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SCALE: begin
                n_acc  = w_acc;
                n_diff = r_diff << 1;
                n_bit  = r_bit + 1'b1;
                if (r_bit == BIT_W'(ALPHA_BITS - 1)) begin
                    n_slow  = r_slow + w_acc[16 +: SLOW_W];
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= STP_X1;
            r_kind  <= DK_TEMP;
            r_total <= '0;
            r_pos   <= '0;
            r_vld   <= '0;
            r_slow  <= '0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_kind  <= n_kind;
            r_total <= n_total;
            r_pos   <= n_pos;
            r_vld   <= n_vld;
            r_slow  <= n_slow;
            r_bit   <= n_bit;
        end
        r_up    <= n_up;
        r_ut    <= n_ut;
        r_x1    <= n_x1;
        r_b5    <= n_b5;
        r_b6    <= n_b6;
        r_sq    <= n_sq;
        r_x3    <= n_x3;
        r_b3    <= n_b3;
        r_b4    <= n_b4;
        r_b7    <= n_b7;
        r_p     <= n_p;
        r_tmp   <= n_tmp;
        r_prod  <= n_prod;
        r_mean  <= n_mean;
        r_sign  <= n_sign;
        r_fault <= n_fault;
        r_diff  <= n_diff;
        r_acc   <= n_acc;
    end

    bca_ram #(
        .WIDTH (32),
        .DEPTH (WINDOW_SAMPLES)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_pos),
        .i_wdata (w_pn),
        .i_re    (w_ram_re),
        .i_raddr (r_pos),
        .o_rdata (w_ram_rdata)
    );

    bca_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_cfg_ready           = 1'b1;
    assign o_ready               = (r_state == ST_IDLE);
    assign o_valid               = (r_state == ST_DONE);
    assign o_temperature_decideg = signed'(w_t8[19:4]);
    assign o_pressure_pa         = signed'(r_p);
    assign o_pressure_mean_pa    = signed'(r_mean);
    assign o_pressure_slow_q16   = signed'(r_slow);
    assign o_divide_fault        = r_fault;
endmodule

// ----- design/bca_checker.sv -----
// ----------------------------------------------------------------------------
// bca_checker
// Port level checks of the barometer compensation block.
// ----------------------------------------------------------------------------
module bca_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_pressure_pa
);
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pressure_pa))
        else $error("result word changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready && !o_valid)
        else $error("block not busy after accepting a word");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while result pending");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("output valid after reset");
endmodule

bind barometer_compensation_average bca_checker u_bca_checker (.*);
